@@ rtl/spjsd_pkg.sv @@
// spjsd_pkg: request and response types, states and constants of the
// sparse profile jensen-shannon merge block; no dependencies
package spjsd_pkg;

   localparam int KEY_W  = 64;
   localparam int PROB_W = 33;
   localparam int FRAC   = 32;
   localparam int ENT_W  = 48;

   typedef struct packed {
      logic              source;
      logic [KEY_W-1:0]  entry_key;
      logic [PROB_W-1:0] entry_prob;
      logic              profile_end;
   } req_type;

   typedef struct packed {
      logic              next_source;
      logic              done_res;
      logic [PROB_W-1:0] divergence;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_TERM,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      TRM_PSELF,
      TRM_QSELF,
      TRM_MIX
   } term_type;

   typedef struct packed {
      logic        start;
      logic [33:0] value;
      logic        wide;
   } xlog_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] term;
   } xlog_rsp_type;

endpackage

@@ rtl/sparse_profile_jsd_merge.sv @@
// sparse_profile_jsd_merge: top level, merge sequencer and entropy sums
// depends on spjsd_pkg and spjsd_xlog
//
// channel  dir  handshake          payload
// req      in   req_valid/stall    req_type
// rsp      out  rsp_valid/stall    rsp_type
//
// each x*log2(x) term runs on the shared unit in order: start, normalize,
// 32 squarings, multiply, shift and done
// a merge costs one pick state plus three terms for equal keys, else two
// a request with no merge has its response offered after the pick and finish states
// reset clears heads, sums and the sequencer
// req_stall is high from acceptance until the response is taken

module sparse_profile_jsd_merge import spjsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [ENT_W-1:0] ENT_MAX = '1;
   localparam logic [PROB_W-1:0] ONE = PROB_W'(1) << FRAC;

   state_type   state_ff, state_in;
   term_type    trm_ff, trm_in;
   logic        pv_ff, pv_in, qv_ff, qv_in, pe_ff, pe_in, qe_ff, qe_in;
   logic [KEY_W-1:0]  pk_ff, pk_in, qk_ff, qk_in;
   logic [PROB_W-1:0] pp_ff, pp_in, qp_ff, qp_in;
   logic [ENT_W-1:0]  hm_ff, hm_in, hp_ff, hp_in, hq_ff, hq_in;
   logic        tp_ff, tp_in, tq_ff, tq_in;
   logic        started_ff, started_in;
   rsp_type     rsp_ff, rsp_in;

   xlog_req_type xq;
   xlog_rsp_type xs;
   logic [PROB_W-1:0] prob;
   logic [63:0]  tsum;
   logic [ENT_W-1:0] acc, accsum;
   logic [ENT_W:0] d1;
   logic [ENT_W-1:0] dd;
   logic         is_last;

   spjsd_xlog u_xlog (.clock(clock), .reset(reset), .ctl(xq), .sts(xs));

   assign prob = (req_data.entry_prob > ONE) ? ONE : req_data.entry_prob;

   always_comb begin
      case (trm_ff)
         TRM_PSELF: acc = hp_ff;
         TRM_QSELF: acc = hq_ff;
         default:   acc = hm_ff;
      endcase
   end
   assign tsum   = 64'(acc) + xs.term;
   assign accsum = (tsum > 64'(ENT_MAX)) ? ENT_MAX : tsum[ENT_W-1:0];
   assign is_last = (trm_ff == TRM_MIX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_PICK;
         ST_PICK: begin
            if ((pv_ff && qv_ff) || (pv_ff && qe_ff) || (qv_ff && pe_ff))
               state_in = ST_TERM;
            else
               state_in = ST_FINISH;
         end
         ST_TERM:   if (xs.done && is_last) state_in = ST_PICK;
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pv_in = pv_ff; qv_in = qv_ff; pe_in = pe_ff; qe_in = qe_ff;
      pk_in = pk_ff; qk_in = qk_ff; pp_in = pp_ff; qp_in = qp_ff;
      hm_in = hm_ff; hp_in = hp_ff; hq_in = hq_ff;
      tp_in = tp_ff; tq_in = tq_ff; trm_in = trm_ff; rsp_in = rsp_ff;
      started_in = 1'b0;
      xq = '0;
      d1 = '0; dd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_data.source && !pe_ff) begin
                  if (req_data.profile_end) pe_in = 1'b1;
                  else if (!pv_ff && prob != '0) begin
                     pv_in = 1'b1; pk_in = req_data.entry_key; pp_in = prob;
                  end
               end
               if (req_data.source && !qe_ff) begin
                  if (req_data.profile_end) qe_in = 1'b1;
                  else if (!qv_ff && prob != '0) begin
                     qv_in = 1'b1; qk_in = req_data.entry_key; qp_in = prob;
                  end
               end
            end
         end
         ST_PICK: begin
            if (pv_ff && qv_ff) begin
               tp_in = pk_ff <= qk_ff; tq_in = qk_ff <= pk_ff;
            end else begin
               tp_in = pv_ff; tq_in = !pv_ff;
            end
            trm_in = (pv_ff && (!qv_ff || pk_ff <= qk_ff)) ? TRM_PSELF : TRM_QSELF;
            started_in = 1'b0;
         end
         ST_TERM: begin
            if (!xs.busy && !started_ff) begin
               xq.start = 1'b1;
               case (trm_ff)
                  TRM_PSELF: begin xq.value = 34'(pp_ff); xq.wide = 1'b0; end
                  TRM_QSELF: begin xq.value = 34'(qp_ff); xq.wide = 1'b0; end
                  default: begin
                     xq.wide = 1'b1;
                     if (tp_ff && tq_ff) xq.value = 34'(pp_ff) + 34'(qp_ff);
                     else if (tp_ff) xq.value = 34'(pp_ff);
                     else xq.value = 34'(qp_ff);
                  end
               endcase
               started_in = 1'b1;
            end else begin
               started_in = started_ff;
            end
            if (xs.done) begin
               started_in = 1'b0;
               case (trm_ff)
                  TRM_PSELF: begin
                     hp_in = accsum;
                     trm_in = (tp_ff && tq_ff) ? TRM_QSELF : TRM_MIX;
                  end
                  TRM_QSELF: begin hq_in = accsum; trm_in = TRM_MIX; end
                  default: begin
                     hm_in = accsum;
                     if (tp_ff) pv_in = 1'b0;
                     if (tq_ff) qv_in = 1'b0;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            rsp_in = '0;
            if (pe_ff && qe_ff) begin
               if (hm_ff > hp_ff) begin
                  d1 = {1'b0, hm_ff - hp_ff};
                  dd = (d1[ENT_W-1:0] > hq_ff) ? d1[ENT_W-1:0] - hq_ff : '0;
               end
               dd = dd >> 1;
               rsp_in.divergence = (dd > ENT_W'(ONE)) ? ONE : dd[PROB_W-1:0];
               rsp_in.done_res = 1'b1;
               pv_in = 1'b0; qv_in = 1'b0; pe_in = 1'b0; qe_in = 1'b0;
               pk_in = '0; qk_in = '0; pp_in = '0; qp_in = '0;
               hm_in = '0; hp_in = '0; hq_in = '0;
            end else if (!pv_ff && !pe_ff) begin
               rsp_in.next_source = 1'b0;
            end else if (!qv_ff && !qe_ff) begin
               rsp_in.next_source = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff <= 1'b0; qv_ff <= 1'b0; pe_ff <= 1'b0; qe_ff <= 1'b0;
         pk_ff <= '0; qk_ff <= '0; pp_ff <= '0; qp_ff <= '0;
         hm_ff <= '0; hp_ff <= '0; hq_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff <= pv_in; qv_ff <= qv_in; pe_ff <= pe_in; qe_ff <= qe_in;
         pk_ff <= pk_in; qk_ff <= qk_in; pp_ff <= pp_in; qp_ff <= qp_in;
         hm_ff <= hm_in; hp_ff <= hp_in; hq_ff <= hq_in;
         started_ff <= started_in;
      end
      tp_ff <= tp_in; tq_ff <= tq_in; trm_ff <= trm_in; rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("response while open");
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.divergence == '0)
      else $error("divergence without done");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.divergence <= ONE) else $error("divergence range");
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !pe_ff && !qe_ff && hm_ff == '0)
      else $error("state not cleared");
`endif

endmodule

@@ rtl/spjsd_xlog.sv @@
// spjsd_xlog: iterative -x*log2(x) unit, one squaring step per cycle
// depends on spjsd_pkg
module spjsd_xlog import spjsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  xlog_req_type ctl,
   output xlog_rsp_type sts
);

   typedef enum logic [2:0] {
      X_IDLE, X_NORM, X_SQ, X_MUL, X_SHIFT, X_DONE
   } xst_type;

   xst_type     state_ff, state_in;
   logic [33:0] v_ff, v_in;
   logic        wide_ff, wide_in;
   logic [5:0]  k_ff, k_in;
   logic [32:0] m_ff, m_in;
   logic [31:0] frac_ff, frac_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [65:0] prod_ff, prod_in;
   logic [63:0] term_ff, term_in;

   logic [65:0] sq;
   logic [34:0] m_next;
   logic [5:0]  top;
   logic [38:0] lval;
   logic [38:0] nl;
   logic [65:0] prod_full;

   always_comb begin
      top = '0;
      for (int i = 0; i < 34; i++) begin
         if (v_ff[i]) begin
            top = 6'(i);
         end
      end
   end

   assign sq     = 66'(m_ff) * 66'(m_ff);
   assign m_next = 35'(sq >> 31);
   assign lval   = {1'b0, k_ff, frac_ff};
   assign nl     = (wide_ff ? 39'(33) << FRAC : 39'(32) << FRAC) - lval;
   // upper bits of the log term folded onto the low partial product
   assign prod_full = prod_ff + (66'(v_ff) * 66'(nl[38:32]) << 32);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         X_IDLE:  if (ctl.start) state_in = (ctl.value == '0) ? X_DONE : X_NORM;
         X_NORM:  state_in = X_SQ;
         X_SQ:    if (cnt_ff == 6'(FRAC - 1)) state_in = X_MUL;
         X_MUL:   state_in = X_SHIFT;
         X_SHIFT: state_in = X_DONE;
         X_DONE:  state_in = X_IDLE;
         default: state_in = X_IDLE;
      endcase
   end

   always_comb begin
      v_in = v_ff; wide_in = wide_ff; k_in = k_ff; m_in = m_ff;
      frac_in = frac_ff; cnt_in = cnt_ff; prod_in = prod_ff; term_in = term_ff;
      case (state_ff)
         X_IDLE: begin
            v_in = ctl.value; wide_in = ctl.wide; term_in = '0;
         end
         X_NORM: begin
            k_in = top; frac_in = '0; cnt_in = '0;
            if (top >= 6'd31) m_in = 33'(v_ff >> (top - 6'd31));
            else m_in = 33'(v_ff << (6'd31 - top));
         end
         X_SQ: begin
            cnt_in = cnt_ff + 6'd1;
            if (m_next[34:32] != '0) begin
               frac_in = {frac_ff[30:0], 1'b1};
               m_in = m_next[33:1];
            end else begin
               frac_in = {frac_ff[30:0], 1'b0};
               m_in = m_next[32:0];
            end
         end
         X_MUL:   prod_in = 66'(v_ff) * 66'(nl[31:0]);
         X_SHIFT: term_in = wide_ff ? 64'(prod_full >> 33) : 64'(prod_full >> 32);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= X_IDLE;
      else state_ff <= state_in;
      v_ff <= v_in; wide_ff <= wide_in; k_ff <= k_in; m_ff <= m_in;
      frac_ff <= frac_in; cnt_ff <= cnt_in; prod_ff <= prod_in; term_ff <= term_in;
   end

   assign sts.busy = (state_ff != X_IDLE);
   assign sts.done = (state_ff == X_DONE);
   assign sts.term = term_ff;

`ifndef ASSERT_OFF
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == X_DONE |=> state_ff == X_IDLE) else $error("xlog done");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == X_SQ |-> cnt_ff < 6'(FRAC)) else $error("xlog count");
   a_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == X_MUL |=> state_ff == X_SHIFT) else $error("xlog mul");
`endif

endmodule

@@ dv/spjsd_checker.sv @@
// spjsd_checker: watches the request and response channels of the sparse
// profile merge block, predicts every response and compares it
// depends on spjsd_pkg
`timescale 1ns / 1ps

module spjsd_checker import spjsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);

   localparam logic [63:0] ENT_MAX  = (64'd1 << ENT_W) - 1;
   localparam logic [63:0] PROB_ONE = 64'd1 << FRAC;

   rsp_type     rsp_expected[$];
   logic        p_hv, q_hv, p_end, q_end;
   logic [63:0] p_key, q_key, p_prob, q_prob;
   logic [63:0] h_mix, h_p, h_q;

   function automatic logic [63:0] log2_fx(logic [63:0] v);
      int          k;
      logic [63:0] m, frac;
      k = 0;
      frac = 0;
      while (k < 63 && (v >> (k + 1)) != 0) k++;
      m = (k >= 31) ? (v >> (k - 31)) : (v << (31 - k));
      for (int i = 0; i < FRAC; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 64'd1;
            m = m >> 1;
         end
      end
      return (64'(k) << FRAC) | frac;
   endfunction

   function automatic logic [63:0] xlog_term(logic [63:0] v, int s);
      logic [63:0]  nl;
      logic [127:0] prod;
      if (v == 0) return 64'd0;
      nl = (64'(s) << FRAC) - log2_fx(v);
      prod = {64'd0, v} * {64'd0, nl};
      return 64'(prod >> s);
   endfunction

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (s < a || s > ENT_MAX) return ENT_MAX;
      return s;
   endfunction

   task automatic clear_merge();
      p_hv = 0; q_hv = 0; p_end = 0; q_end = 0;
      p_key = 0; q_key = 0; p_prob = 0; q_prob = 0;
      h_mix = 0; h_p = 0; h_q = 0;
   endtask

   task automatic merge_request(req_type r);
      logic [63:0] prob, d;
      logic        take_p, take_q;
      rsp_type     e;
      prob = 64'(r.entry_prob);
      e = '0;
      if (prob > PROB_ONE) prob = PROB_ONE;
      if (r.source == 1'b0) begin
         if (!p_end) begin
            if (r.profile_end) p_end = 1;
            else if (!p_hv && prob != 0) begin
               p_hv = 1; p_key = r.entry_key; p_prob = prob;
            end
         end
      end else begin
         if (!q_end) begin
            if (r.profile_end) q_end = 1;
            else if (!q_hv && prob != 0) begin
               q_hv = 1; q_key = r.entry_key; q_prob = prob;
            end
         end
      end
      forever begin
         if (p_hv && q_hv) begin
            take_p = p_key <= q_key;
            take_q = q_key <= p_key;
         end else if (p_hv && q_end) begin
            take_p = 1; take_q = 0;
         end else if (q_hv && p_end) begin
            take_p = 0; take_q = 1;
         end else break;
         if (take_p && take_q) begin
            h_mix = sat_add(h_mix, xlog_term(p_prob + q_prob, FRAC + 1));
            h_p = sat_add(h_p, xlog_term(p_prob, FRAC));
            h_q = sat_add(h_q, xlog_term(q_prob, FRAC));
            p_hv = 0; q_hv = 0;
         end else if (take_p) begin
            h_p = sat_add(h_p, xlog_term(p_prob, FRAC));
            h_mix = sat_add(h_mix, xlog_term(p_prob, FRAC + 1));
            p_hv = 0;
         end else begin
            h_q = sat_add(h_q, xlog_term(q_prob, FRAC));
            h_mix = sat_add(h_mix, xlog_term(q_prob, FRAC + 1));
            q_hv = 0;
         end
      end
      if (p_end && q_end && !p_hv && !q_hv) begin
         d = 0;
         if (h_mix > h_p) begin
            d = h_mix - h_p;
            d = (d > h_q) ? d - h_q : 64'd0;
         end
         d = d >> 1;
         e.divergence = PROB_W'((d > PROB_ONE) ? PROB_ONE : d);
         e.done_res = 1;
         clear_merge();
      end else if (!p_hv && !p_end) e.next_source = 0;
      else if (!q_hv && !q_end) e.next_source = 1;
      rsp_expected = {rsp_expected, e};
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s differs, got %h expected %h", $realtime, what, got, want);
      errors++;
   endtask

   initial begin
      errors = 0;
      pending = 0;
      clear_merge();
   end

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         clear_merge();
         rsp_expected.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expected.size() == 0)
               report("unexpected response", 64'(rsp_data), 64'd0);
            else begin
               e = rsp_expected.pop_front();
               if (rsp_data.next_source !== e.next_source)
                  report("next_source", 64'(rsp_data.next_source), 64'(e.next_source));
               if (rsp_data.done_res !== e.done_res)
                  report("done_res", 64'(rsp_data.done_res), 64'(e.done_res));
               if (rsp_data.divergence !== e.divergence)
                  report("divergence", 64'(rsp_data.divergence), 64'(e.divergence));
            end
         end
         if (req_valid && !req_stall) merge_request(req_data);
      end
      pending = rsp_expected.size();
   end

endmodule

@@ dv/sparse_profile_jsd_merge_test.sv @@
// sparse_profile_jsd_merge_test: drives sorted profile pairs, noise and
// directed requests into the merge block; checking is done by spjsd_checker
// depends on spjsd_pkg, spjsd_checker and sparse_profile_jsd_merge
`timescale 1ns / 1ps

module sparse_profile_jsd_merge_test;
   import spjsd_pkg::*;

   localparam int LIMIT = 2000000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      errors, pending;
   int      cycles = 0;
   int      sent = 0;
   int      send_idle = 9, recv_idle = 82;
   logic    hold_go = 0;
   logic    hold_done = 0;
   int      hold_cnt = 0;

   logic        f_phv, f_qhv, f_pend, f_qend, f_fin;
   logic [63:0] f_pkey, f_qkey;

   sparse_profile_jsd_merge u_top (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   spjsd_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .errors, .pending
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_go && !hold_done && hold_cnt == 0) begin
         hold_cnt <= 600;
         hold_done <= 1;
         rsp_stall <= 1;
      end else if (hold_cnt > 1) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1;
      end else begin
         hold_cnt <= 0;
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // feeder copy of heads and ends, keys only
   task automatic track(req_type r);
      logic [63:0] prob;
      prob = 64'(r.entry_prob);
      if (!r.source && !f_pend) begin
         if (r.profile_end) f_pend = 1;
         else if (!f_phv && prob != 0) begin f_phv = 1; f_pkey = r.entry_key; end
      end else if (r.source && !f_qend) begin
         if (r.profile_end) f_qend = 1;
         else if (!f_qhv && prob != 0) begin f_qhv = 1; f_qkey = r.entry_key; end
      end
      forever begin
         if (f_phv && f_qhv) begin
            if (f_pkey <= f_qkey && f_qkey <= f_pkey) begin f_phv = 0; f_qhv = 0; end
            else if (f_pkey < f_qkey) f_phv = 0;
            else f_qhv = 0;
         end else if (f_phv && f_qend) f_phv = 0;
         else if (f_qhv && f_pend) f_qhv = 0;
         else break;
      end
      if (f_pend && f_qend && !f_phv && !f_qhv) begin
         f_pend = 0; f_qend = 0; f_fin = 1;
      end
   endtask

   task automatic send(logic src, logic [63:0] key, logic [32:0] prob, logic fin);
      req_type r;
      r.source = src; r.entry_key = key; r.entry_prob = prob; r.profile_end = fin;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track(r);
      sent++;
   endtask

   function automatic logic [32:0] rand_prob();
      int c;
      c = $urandom_range(99);
      if (c < 6) return 33'd0;
      if (c < 12) return 33'h1_0000_0000;
      if (c < 18) return 33'({$urandom, $urandom});
      if (c < 60) return 33'($urandom_range(1, 32'h0800_0000));
      return 33'($urandom);
   endfunction

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   task automatic profile_pair();
      logic [63:0] pk[8], qk[8], key;
      logic [32:0] pp[8], qp[8];
      int          n, m, pi, qi, c;
      n = 0; m = 0; pi = 0; qi = 0;
      key = rand_key() >> $urandom_range(1, 40);
      while (n < 7 && m < 7 && $urandom_range(9) < 8) begin
         key = key + $urandom_range(1, 1000);
         c = $urandom_range(2);
         if (c != 1) begin pk[n] = key; pp[n] = rand_prob(); n++; end
         if (c != 0) begin qk[m] = key; qp[m] = rand_prob(); m++; end
      end
      f_fin = 0;
      while (!f_fin) begin
         if ($urandom_range(99) < 5)
            send(1'($urandom_range(1)), rand_key(), rand_prob(), $urandom_range(9) == 0);
         else if (!f_phv && !f_pend) begin
            if (pi < n) begin send(0, pk[pi], pp[pi], 0); pi++; end
            else send(0, rand_key(), rand_prob(), 1);
         end else begin
            if (qi < m) begin send(1, qk[qi], qp[qi], 0); qi++; end
            else send(1, rand_key(), rand_prob(), 1);
         end
      end
   endtask

   initial begin
      f_phv = 0; f_qhv = 0; f_pend = 0; f_qend = 0; f_fin = 0;
      f_pkey = 0; f_qkey = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes, equal keys, zero and oversized probabilities
      send(0, 64'd0, 33'h1_0000_0000, 0);
      send(1, 64'd0, 33'h1_FFFF_FFFF, 0);
      send(0, 64'd5, 33'd0, 0);
      send(0, 64'd5, 33'd1, 0);
      send(0, 64'd6, 33'd7, 0);
      send(1, 64'd9, 33'h0_8000_0000, 0);
      send(1, 64'd3, 33'd100, 0);
      send(0, 64'hFFFF_FFFF_FFFF_FFFF, 33'h0_FFFF_FFFF, 0);
      send(0, 64'd1, 33'd1, 1);
      send(0, 64'd2, 33'd1, 1);
      send(0, 64'd2, 33'd1, 0);
      send(1, 64'hFFFF_FFFF_FFFF_FFFF, 33'h0_4000_0000, 0);
      send(1, 64'd0, 33'd0, 1);
      send(1, 64'd0, 33'd0, 1);
      send(0, 64'd0, 33'd0, 1);
      send(1, 64'd0, 33'd0, 1);
      send(0, 64'h8000_0000_0000_0000, 33'h1_0000_0000, 0);
      send(1, 64'h8000_0000_0000_0000, 33'h1_0000_0000, 0);
      send(0, 64'd0, 33'd0, 1);
      send(1, 64'd0, 33'd0, 1);

      hold_go <= 1;
      while (sent < 240) profile_pair();
      send_idle = 82; recv_idle = 9;
      while (sent < 470) profile_pair();
      send_idle = 0; recv_idle = 0;
      while (sent < 700) profile_pair();
      req_valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
